// ===== src/arq_pkg.sv =====
// Shared types and codes for the address region table.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package arq_pkg;

    // Operation carried in the input tuser.
    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_CLEAR  = 2'd3
    } arq_action_t;

    // Result code carried in the output tuser.
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } arq_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FINISH
    } arq_state_t;

    // Per-cell control: rotate one place, or take a broadcast entry instead.
    typedef struct packed {
        logic shift;
        logic load;
    } arq_ctl_t;

endpackage

`default_nettype wire

// ===== src/arq_cell.sv =====
// One cell of the rotating region ring: start, end, protection and flags.
// Depends on arq_pkg for the cell control struct.
`default_nettype none

module arq_cell #(
    parameter int unsigned AW = 32
) (
    input  wire logic              clk,
    input  wire arq_pkg::arq_ctl_t ctl,
    input  wire logic [AW-1:0]     shift_start,
    input  wire logic [AW-1:0]     shift_end,
    input  wire logic [31:0]       shift_prot,
    input  wire logic [31:0]       shift_flags,
    input  wire logic [AW-1:0]     load_start,
    input  wire logic [AW-1:0]     load_end,
    input  wire logic [31:0]       load_prot,
    input  wire logic [31:0]       load_flags,
    output logic      [AW-1:0]     q_start,
    output logic      [AW-1:0]     q_end,
    output logic      [31:0]       q_prot,
    output logic      [31:0]       q_flags
);
    import arq_pkg::*;

    logic [AW-1:0] start_reg;
    logic [AW-1:0] end_reg;
    logic [31:0]   prot_reg;
    logic [31:0]   flags_reg;

    // A load wins over the shift so a new entry lands where its slot will be.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            start_reg <= load_start;
            end_reg   <= load_end;
            prot_reg  <= load_prot;
            flags_reg <= load_flags;
        end
        else if (ctl.shift)
        begin
            start_reg <= shift_start;
            end_reg   <= shift_end;
            prot_reg  <= shift_prot;
            flags_reg <= shift_flags;
        end
    end

    assign q_start = start_reg;
    assign q_end   = end_reg;
    assign q_prot  = prot_reg;
    assign q_flags = flags_reg;

endmodule

`default_nettype wire

// ===== src/address_region_table.sv =====
// Top level of the address region table: control, valid bits and the cell ring.
// Depends on arq_pkg and arq_cell.
//
// Usage: a request word enters on the s_axis channel, the operation code in
// s_axis_tuser and the range, protection, flag and lookup address fields in
// s_axis_tdata. One response word per request leaves on m_axis: the status
// code in m_axis_tuser and the hit fields plus the region count in tdata.
//
// The region entries sit in a ring of SLOTS cells that rotates by one cell
// every cycle of a pass. The cell at the head always holds slot k of the pass,
// so the one compare unit at the head visits the slots in ascending order.
// After a whole pass the ring is back in its home order. Valid bits are
// kept apart by slot number, which lets an insert or the tail of a split be
// written straight into the lowest free slot wherever it is in the ring.
//
// Each request goes from S_IDLE, where it is accepted, through S_RUN, the pass
// over the ring, to S_FINISH, which hands the result to the output register;
// a new request is accepted only in S_IDLE, so a request is not taken before
// the last one is through. The output register holds a result until m_axis_tready;
// a finished pass waits in its last state while the previous word is unread.
//
// Reset clears all valid bits and the region count; entry payloads are left
// as they are and are never read before being written.
`default_nettype none

module address_region_table #(
    parameter int unsigned SLOTS     = 16,
    parameter int unsigned ADDR_BITS = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    // Request channel.
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata, lowest bit up: range_start, range_end, prot_bits, flag_bits,
    // lookup_address (32 bits each).
    input  wire logic [159:0] s_axis_tdata,
    // tuser, lowest bit up: action (2 bits).
    input  wire logic [1:0]   s_axis_tuser,
    // Response channel.
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata, lowest bit up: hit_start, hit_end, hit_prot, hit_flags
    // (32 bits each), region_count, zero fill to a whole byte.
    output logic [((128 + $clog2(SLOTS + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // tuser, lowest bit up: status (2 bits).
    output logic [1:0]        m_axis_tuser
);
    import arq_pkg::*;

    localparam int unsigned AW  = ADDR_BITS;
    localparam int unsigned IW  = $clog2(SLOTS);
    localparam int unsigned CW  = $clog2(SLOTS + 1);
    localparam int unsigned TDW = ((128 + CW + 7) / 8) * 8;

    // Cell outputs, indexed by ring position (position 0 is the head).
    logic [AW-1:0] c_start [SLOTS];
    logic [AW-1:0] c_end   [SLOTS];
    logic [31:0]   c_prot  [SLOTS];
    logic [31:0]   c_flags [SLOTS];
    arq_ctl_t      c_ctl   [SLOTS];

    arq_state_t    state_reg, state_next;
    logic [IW-1:0] k_reg, k_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [CW-1:0] count_reg, count_next;

    // Request fields captured at acceptance.
    arq_action_t   act_reg;
    logic [AW-1:0] lo_reg, hi_reg, addr_reg;
    logic [31:0]   prot_in_reg, flags_in_reg;

    // Result being built during the pass.
    arq_status_t   st_reg, st_next;
    logic          found_reg, found_next;
    logic [AW-1:0] hs_reg, hs_next, he_reg, he_next;
    logic [31:0]   hp_reg, hp_next, hf_reg, hf_next;

    // Output register.
    logic          out_valid_reg;
    arq_status_t   out_st_reg;
    logic [31:0]   out_hs_reg, out_he_reg, out_hp_reg, out_hf_reg;
    logic [CW-1:0] out_cnt_reg;

    // Head processing.
    logic [AW-1:0] head_start, head_end;
    logic          head_valid;
    logic          free_any;
    logic [IW-1:0] free_idx;
    logic          load_en;
    logic [AW-1:0] load_start, load_end;
    logic [31:0]   load_prot, load_flags;
    logic [IW:0]   pos_raw;
    logic [IW-1:0] load_pos;
    logic          accept;
    logic          last_step;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign head_valid    = valid_reg[k_reg];
    assign last_step     = (k_reg == IW'(SLOTS - 1));

    // Lowest free slot in the current valid vector.
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    // Where slot free_idx sits in the ring after this cycle's rotation.
    always_comb
    begin
        pos_raw = (IW + 1)'(free_idx) + (IW + 1)'(SLOTS - 1) - (IW + 1)'(k_reg);
        if (pos_raw >= (IW + 1)'(SLOTS))
        begin
            pos_raw = pos_raw - (IW + 1)'(SLOTS);
        end
        load_pos = pos_raw[IW-1:0];
    end

    // Controller: next state, head update and result building.
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        valid_next = valid_reg;
        count_next = count_reg;
        st_next    = st_reg;
        found_next = found_reg;
        hs_next    = hs_reg;
        he_next    = he_reg;
        hp_next    = hp_reg;
        hf_next    = hf_reg;
        head_start = c_start[0];
        head_end   = c_end[0];
        load_en    = 1'b0;
        load_start = lo_reg;
        load_end   = hi_reg;
        load_prot  = prot_in_reg;
        load_flags = flags_in_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RUN;
                    k_next     = '0;
                    st_next    = ST_OK;
                    found_next = 1'b0;
                    hs_next    = '0;
                    he_next    = '0;
                    hp_next    = '0;
                    hf_next    = '0;
                end
            end
            S_RUN:
            begin
                case (act_reg)
                    ACT_INSERT:
                    begin
                        if (k_reg == '0)
                        begin
                            if (free_any)
                            begin
                                load_en              = 1'b1;
                                valid_next[free_idx] = 1'b1;
                                count_next           = count_reg + 1'b1;
                            end
                            else
                            begin
                                st_next = ST_FULL;
                            end
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (head_valid && !(c_start[0] >= hi_reg || c_end[0] <= lo_reg))
                        begin
                            if (c_start[0] >= lo_reg && c_end[0] <= hi_reg)
                            begin
                                valid_next[k_reg] = 1'b0;
                                count_next        = count_reg - 1'b1;
                            end
                            else if (c_start[0] < lo_reg && c_end[0] > lo_reg
                                     && c_end[0] <= hi_reg)
                            begin
                                head_end = lo_reg;
                            end
                            else if (c_start[0] >= lo_reg && c_start[0] < hi_reg
                                     && c_end[0] > hi_reg)
                            begin
                                head_start = hi_reg;
                            end
                            else if (c_start[0] < lo_reg && c_end[0] > hi_reg)
                            begin
                                // Split: the tail goes to the lowest free slot, if there is one.
                                head_end = lo_reg;
                                if (free_any)
                                begin
                                    load_en              = 1'b1;
                                    load_start           = hi_reg;
                                    load_end             = c_end[0];
                                    load_prot            = c_prot[0];
                                    load_flags           = c_flags[0];
                                    valid_next[free_idx] = 1'b1;
                                    count_next           = count_reg + 1'b1;
                                end
                                else
                                begin
                                    st_next = ST_FULL;
                                end
                            end
                        end
                    end
                    ACT_LOOKUP:
                    begin
                        if (!found_reg && head_valid && addr_reg >= c_start[0]
                            && addr_reg < c_end[0])
                        begin
                            found_next = 1'b1;
                            hs_next    = c_start[0];
                            he_next    = c_end[0];
                            hp_next    = c_prot[0];
                            hf_next    = c_flags[0];
                        end
                    end
                    ACT_CLEAR:
                    begin
                        valid_next[k_reg] = 1'b0;
                        count_next        = '0;
                    end
                    default:
                    begin
                    end
                endcase
                if (last_step)
                begin
                    k_next     = '0;
                    state_next = S_FINISH;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The cell chain: each cell takes its upper neighbor, the last one takes
    // the processed head entry.
    for (genvar j = 0; j < SLOTS; j++)
    begin : g_cell
        logic [AW-1:0] sh_start, sh_end;
        logic [31:0]   sh_prot, sh_flags;

        if (j == SLOTS - 1)
        begin : g_tail
            assign sh_start = head_start;
            assign sh_end   = head_end;
            assign sh_prot  = c_prot[0];
            assign sh_flags = c_flags[0];
        end
        else
        begin : g_mid
            assign sh_start = c_start[j+1];
            assign sh_end   = c_end[j+1];
            assign sh_prot  = c_prot[j+1];
            assign sh_flags = c_flags[j+1];
        end

        assign c_ctl[j].shift = (state_reg == S_RUN);
        assign c_ctl[j].load  = load_en && (load_pos == IW'(j));

        arq_cell #(
            .AW (AW)
        ) u_cell (
            .clk         (clk),
            .ctl         (c_ctl[j]),
            .shift_start (sh_start),
            .shift_end   (sh_end),
            .shift_prot  (sh_prot),
            .shift_flags (sh_flags),
            .load_start  (load_start),
            .load_end    (load_end),
            .load_prot   (load_prot),
            .load_flags  (load_flags),
            .q_start     (c_start[j]),
            .q_end       (c_end[j]),
            .q_prot      (c_prot[j]),
            .q_flags     (c_flags[j])
        );
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            valid_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            valid_reg <= valid_next;
            count_reg <= count_next;
            if (state_reg == S_FINISH && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg      <= arq_action_t'(s_axis_tuser);
            lo_reg       <= AW'(s_axis_tdata[31:0]);
            hi_reg       <= AW'(s_axis_tdata[63:32]);
            prot_in_reg  <= s_axis_tdata[95:64];
            flags_in_reg <= s_axis_tdata[127:96];
            addr_reg     <= AW'(s_axis_tdata[159:128]);
        end
        st_reg    <= st_next;
        found_reg <= found_next;
        hs_reg    <= hs_next;
        he_reg    <= he_next;
        hp_reg    <= hp_next;
        hf_reg    <= hf_next;
        if (state_reg == S_FINISH && (!out_valid_reg || m_axis_tready))
        begin
            out_cnt_reg <= count_reg;
            if (act_reg == ACT_LOOKUP && !found_reg)
            begin
                out_st_reg <= ST_MISS;
            end
            else
            begin
                out_st_reg <= st_reg;
            end
            out_hs_reg <= 32'(hs_reg);
            out_he_reg <= 32'(he_reg);
            out_hp_reg <= hp_reg;
            out_hf_reg <= hf_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_st_reg;
    assign m_axis_tdata  = TDW'({out_cnt_reg, out_hf_reg, out_hp_reg, out_he_reg, out_hs_reg});

endmodule

`default_nettype wire

// ===== src/arq_checker.sv =====
// Port-level checks for the address region table, bound to the top level.
// Depends on arq_pkg for the status codes.
`default_nettype none

module arq_checker #(
    parameter int unsigned SLOTS = 16
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_axis_tvalid,
    input wire logic s_axis_tready,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic [((128 + $clog2(SLOTS + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input wire logic [1:0] m_axis_tuser
);
    import arq_pkg::*;

    localparam int unsigned CW = $clog2(SLOTS + 1);

    // The region count can never exceed the number of slots.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[128 +: CW] <= CW'(SLOTS)))
        else $error("region count above slot count");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_FULL
                           || m_axis_tuser == ST_MISS))
        else $error("undefined status code");

    // Only a lookup hit carries region data; checked on every response whose status is not ST_OK.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata[127:0] == '0))
        else $error("hit fields set without a hit");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("response changed while stalled");

endmodule

bind address_region_table arq_checker #(.SLOTS(SLOTS)) u_arq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the address region table: random and directed insert, remove,
// lookup and clear words checked against a predictor. Depends on arq_pkg and the RTL.
`timescale 1ns / 1ps

import arq_pkg::*;

// Keeps a model of the region slots and the queue of responses it predicts.
class region_scoreboard;
    bit          valid_q[16];
    logic [31:0] start_q[16];
    logic [31:0] end_q[16];
    logic [31:0] prot_q[16];
    logic [31:0] flags_q[16];
    int          count;
    logic [1:0]  pend_st[$];
    logic [132:0] pend_data[$];
    int          errors;

    function int lowest_free();
        for (int i = 0; i < 16; i++)
            if (!valid_q[i])
                return i;
        return -1;
    endfunction

    // Applies one accepted request and queues the response it must produce.
    function void note_request(arq_action_t act, logic [31:0] lo, logic [31:0] hi,
                               logic [31:0] prot, logic [31:0] flg, logic [31:0] addr);
        arq_status_t st;
        logic [31:0] hs, he, hp, hf;
        int f;
        st = ST_OK;
        hs = 0; he = 0; hp = 0; hf = 0;
        case (act)
            ACT_INSERT:
            begin
                f = lowest_free();
                if (f >= 0)
                begin
                    valid_q[f] = 1; start_q[f] = lo; end_q[f] = hi;
                    prot_q[f] = prot; flags_q[f] = flg; count++;
                end
                else
                    st = ST_FULL;
            end
            ACT_REMOVE:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    if (!valid_q[i] || start_q[i] >= hi || end_q[i] <= lo)
                        continue;
                    if (start_q[i] >= lo && end_q[i] <= hi)
                    begin
                        valid_q[i] = 0;
                        count--;
                    end
                    else if (start_q[i] < lo && end_q[i] <= hi)
                        end_q[i] = lo;
                    else if (start_q[i] >= lo && end_q[i] > hi)
                        start_q[i] = hi;
                    else
                    begin
                        // Region spans the cut: the tail goes to a free slot if any.
                        f = lowest_free();
                        if (f >= 0)
                        begin
                            valid_q[f] = 1; start_q[f] = hi; end_q[f] = end_q[i];
                            prot_q[f] = prot_q[i]; flags_q[f] = flags_q[i]; count++;
                        end
                        else
                            st = ST_FULL;
                        end_q[i] = lo;
                    end
                end
            end
            ACT_LOOKUP:
            begin
                st = ST_MISS;
                for (int i = 0; i < 16; i++)
                    if (valid_q[i] && addr >= start_q[i] && addr < end_q[i])
                    begin
                        st = ST_OK;
                        hs = start_q[i]; he = end_q[i]; hp = prot_q[i]; hf = flags_q[i];
                        break;
                    end
            end
            default:
            begin
                for (int i = 0; i < 16; i++)
                    valid_q[i] = 0;
                count = 0;
            end
        endcase
        pend_st.push_back(st);
        pend_data.push_back({count[4:0], hf, hp, he, hs});
    endfunction

    function void check_response(logic [1:0] st, logic [132:0] data);
        logic [1:0] exp_st;
        logic [132:0] exp_data;
        if (pend_st.size() == 0)
        begin
            $display("%0t: unexpected response st=%0d data=%h", $time, st, data);
            errors++;
            return;
        end
        exp_st = pend_st.pop_front();
        exp_data = pend_data.pop_front();
        if (st !== exp_st)
        begin
            $display("%0t: status expected %0d actual %0d", $time, exp_st, st);
            errors++;
        end
        for (int k = 0; k < 4; k++)
            if (data[k*32 +: 32] !== exp_data[k*32 +: 32])
            begin
                $display("%0t: hit field %0d expected %h actual %h", $time, k,
                         exp_data[k*32 +: 32], data[k*32 +: 32]);
                errors++;
            end
        if (data[132:128] !== exp_data[132:128])
        begin
            $display("%0t: region count expected %0d actual %0d", $time,
                     exp_data[132:128], data[132:128]);
            errors++;
        end
    endfunction
endclass

module tb_top;
    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = ACT_CLEAR;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [135:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    region_scoreboard board;
    int           cycle_no = 0;

    address_region_table uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #5 clk = ~clk;

    // Draws an idle gap with a chance of 17 in 100, except in a quiet window of the run.
    function automatic bit take_gap();
        if (cycle_no > 3000 && cycle_no < 6000)
            return 0;
        return $urandom_range(99) < 17;
    endfunction

    // Presents one request word and holds it until the block takes it.
    // Valid stays high after an accept unless the next word draws idle gaps first.
    task automatic send_request(arq_action_t act, logic [31:0] lo, logic [31:0] hi,
                                logic [31:0] prot, logic [31:0] flg, logic [31:0] addr);
        while (take_gap())
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {addr, flg, prot, hi, lo};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_request(act, lo, hi, prot, flg, addr);
    endtask

    // Addresses drawn from a small window so that regions overlap often.
    function automatic logic [31:0] near_addr(logic [31:0] base);
        return base + $urandom_range(0, 63);
    endfunction

    // Random word, mostly meaningful inside a small window, sometimes full-range.
    task automatic send_random();
        logic [31:0] base, lo, hi;
        int pick;
        base = ($urandom_range(3) == 0) ? $urandom : 32'h1000;
        lo = near_addr(base);
        hi = ($urandom_range(9) == 0) ? near_addr(base) : lo + $urandom_range(1, 30);
        if ($urandom_range(19) == 0)
        begin
            lo = $urandom;
            hi = $urandom;
        end
        pick = $urandom_range(99);
        if (pick < 35)
            send_request(ACT_INSERT, lo, hi, $urandom, $urandom, 0);
        else if (pick < 60)
            send_request(ACT_REMOVE, lo, hi, $urandom, $urandom, $urandom);
        else if (pick < 97)
            send_request(ACT_LOOKUP, $urandom, $urandom, $urandom, $urandom,
                         ($urandom_range(4) == 0) ? $urandom : near_addr(base));
        else
            send_request(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    always @(posedge clk)
        cycle_no <= cycle_no + 1;

    // Receiver: random back-pressure, one long hold-off to fill the block.
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                board.check_response(m_axis_tuser, m_axis_tdata[132:0]);
            if (cycle_no > 1500 && cycle_no < 1502)
            begin
                m_axis_tready <= 0;
                for (hold = 0; hold < 300; hold++)
                    @(posedge clk);
            end
            m_axis_tready <= !take_gap();
        end
    end

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int waited;
        board = new();
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: empty lookup, extremes, end trim, split, delete, split with full table.
        send_request(ACT_LOOKUP, 0, 0, 0, 0, 0);
        send_request(ACT_INSERT, 32'hFFFF_FFF0, 32'hFFFF_FFFF, '1, '1, 0);
        send_request(ACT_LOOKUP, 0, 0, 0, 0, 32'hFFFF_FFFE);
        send_request(ACT_LOOKUP, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_request(ACT_INSERT, 50, 10, 1, 2, 0);  // inverted region
        send_request(ACT_INSERT, 100, 200, 3, 4, 0);
        send_request(ACT_INSERT, 150, 300, 5, 6, 0);
        send_request(ACT_LOOKUP, 0, 0, 0, 0, 160);  // overlap, lower slot wins
        send_request(ACT_REMOVE, 180, 250, 0, 0, 0);  // trims one tail, splits the other
        send_request(ACT_INSERT, 400, 500, 7, 8, 0);
        send_request(ACT_REMOVE, 420, 440, 0, 0, 0);  // split
        send_request(ACT_LOOKUP, 0, 0, 0, 0, 450);
        send_request(ACT_REMOVE, 0, 32'hFFFF_FFFF, 0, 0, 0);  // delete all, the inverted one too
        send_request(ACT_REMOVE, 300, 100, 0, 0, 0);  // inverted remove
        for (int i = 0; i < 16; i++)
            send_request(ACT_INSERT, 1000, 2000, i, ~i, 0);
        send_request(ACT_INSERT, 1, 2, 0, 0, 0);  // full
        send_request(ACT_REMOVE, 1100, 1200, 0, 0, 0);  // split with no free slot
        send_request(ACT_CLEAR, 0, 0, 0, 0, 0);

        for (int n = 0; n < 1150; n++)
            send_random();
        s_axis_tvalid <= 0;

        waited = 0;
        while (board.pend_st.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
        if (board.pend_st.size() == 0 && board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
